[src/ffd_pkg.sv]
// Shared types, constants and fixed-point helpers for the fisheye forward distortion block.
// No dependencies; used by fisheye_forward_distort and ffd_cordic.
`default_nettype none
package ffd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_DIST_K1  = 3'd4;
  localparam logic [2:0] REG_DIST_K2  = 3'd5;
  localparam logic [2:0] REG_DIST_K3  = 3'd6;
  localparam logic [2:0] REG_DIST_K4  = 3'd7;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // atan(2^-i) in Q2.30, round to nearest
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  // Per-item data carried once the radius is known
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        r;
    logic               rz;    // zero radius
    logic               fpre;  // clips before the radius test
  } pkt_t;

  function automatic sat_t sat64(input logic signed [63:0] s);
    sat_t o;
    if (s > S32_MAX) begin
      o.val = 32'sh7FFFFFFF;
      o.ovf = 1'b1;
    end else if (s < S32_MIN) begin
      o.val = 32'sh80000000;
      o.ovf = 1'b1;
    end else begin
      o.val = s[31:0];
      o.ovf = 1'b0;
    end
    return o;
  endfunction

  // round half up, floor shift, clip
  function automatic sat_t fx_round(input logic signed [63:0] p, input int frac);
    logic signed [63:0] s;
    s = (p + (64'sd1 <<< (frac - 1))) >>> frac;
    return sat64(s);
  endfunction

  function automatic logic signed [33:0] atan_step(input int i, input int frac);
    logic [63:0] a;
    int          sh;
    sh = 30 - frac;
    a  = 64'(ATAN_Q30[i]);
    if (sh > 0) begin
      a = (a + (64'd1 << (sh - 1))) >> sh;
    end
    return 34'(a);
  endfunction

endpackage
`default_nettype wire

[src/ffd_div.sv]
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, truncated, clipped to 32 bits.
// One quotient bit per stage; side data travels alongside. No package use.
`default_nettype none
module ffd_div #(
  parameter int FRAC_BITS = 24,
  parameter int SB_W      = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic [30:0]        den_i,
  input  wire logic [SB_W-1:0]    sb_i,
  output logic                    valid_o,
  output logic signed [31:0]      quo_o,
  output logic                    ovf_o,
  output logic [SB_W-1:0]         sb_o
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int QB = 33;

  logic [31:0]     mag;
  logic [NW-1:0]   nfull, hi;
  logic [QB:0]     vld_q;
  logic [31:0]     rem_q  [QB+1];
  logic [QB-1:0]   nlo_q  [QB+1];
  logic [QB-1:0]   quo_q  [QB+1];
  logic [30:0]     den_q  [QB+1];
  logic [SB_W-1:0] sb_q   [QB+1];
  logic            neg_q  [QB+1];
  logic            big_q  [QB+1];
  logic            dz_q   [QB+1];
  logic            nz_q   [QB+1];

  assign mag   = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign nfull = {mag, {FRAC_BITS{1'b0}}};
  assign hi    = nfull >> QB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi[31:0];
      nlo_q[0] <= nfull[QB-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      sb_q[0]  <= sb_i;
      neg_q[0] <= num_i[31];
      big_q[0] <= hi >= NW'(den_i);
      dz_q[0]  <= den_i == '0;
      nz_q[0]  <= mag != '0;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [32:0] t;
    logic        ge;
    assign t  = {rem_q[i-1], nlo_q[i-1][QB-1]};
    assign ge = t >= {2'b00, den_q[i-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? 32'(t - {2'b00, den_q[i-1]}) : t[31:0];
        nlo_q[i] <= nlo_q[i-1] << 1;
        quo_q[i] <= {quo_q[i-1][QB-2:0], ge};
        den_q[i] <= den_q[i-1];
        sb_q[i]  <= sb_q[i-1];
        neg_q[i] <= neg_q[i-1];
        big_q[i] <= big_q[i-1];
        dz_q[i]  <= dz_q[i-1];
        nz_q[i]  <= nz_q[i-1];
      end
    end
  end

  logic [QB-1:0]      q;
  logic signed [31:0] res;
  logic               ovf;

  always_comb begin
    q   = quo_q[QB];
    res = '0;
    ovf = 1'b0;
    if (dz_q[QB] || big_q[QB]) begin
      if (nz_q[QB]) begin
        ovf = 1'b1;
        res = neg_q[QB] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
    end else if (neg_q[QB]) begin
      if (q > 33'h080000000) begin
        ovf = 1'b1;
        res = 32'sh80000000;
      end else begin
        res = 32'(33'd0 - q);
      end
    end else begin
      if (q > 33'h07FFFFFFF) begin
        ovf = 1'b1;
        res = 32'sh7FFFFFFF;
      end else begin
        res = q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[QB-1:0], valid_i};
      valid_o <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= res;
      ovf_o <= ovf;
      sb_o  <= sb_q[QB];
    end
  end

endmodule
`default_nettype wire

[src/ffd_isqrt.sv]
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Side data travels alongside. No package use.
`default_nettype none
module ffd_isqrt #(
  parameter int SB_W = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [63:0]     rad_i,
  input  wire logic [SB_W-1:0] sb_i,
  output logic                 valid_o,
  output logic [31:0]          root_o,
  output logic [SB_W-1:0]      sb_o
);

  localparam int NS = 32;

  logic [NS:0]     vld_q;
  logic [63:0]     v_q    [NS+1];
  logic [33:0]     rem_q  [NS+1];
  logic [31:0]     root_q [NS+1];
  logic [SB_W-1:0] sb_q   [NS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0]    <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      sb_q[0]   <= sb_i;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    logic [35:0] t, trial;
    logic        ge;
    assign t     = {rem_q[k-1], v_q[k-1][63:62]};
    assign trial = {2'b00, root_q[k-1], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= v_q[k-1] << 2;
        rem_q[k]  <= ge ? 34'(t - trial) : t[33:0];
        root_q[k] <= {root_q[k-1][30:0], ge};
        sb_q[k]   <= sb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[NS];
  assign root_o  = root_q[NS];
  assign sb_o    = sb_q[NS];

endmodule
`default_nettype wire

[src/ffd_cordic.sv]
// Pipelined vectoring CORDIC giving atan(r) in fixed point, one rotation per stage.
// Depends on ffd_pkg for the arctangent step table.
`default_nettype none
module ffd_cordic #(
  parameter int FRAC_BITS = 24,
  parameter int ITER      = 24,
  parameter int SB_W      = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [30:0]        r_i,
  input  wire logic [SB_W-1:0]    sb_i,
  output logic                    valid_o,
  output logic signed [31:0]      theta_o,
  output logic [SB_W-1:0]         sb_o
);
  import ffd_pkg::*;

  logic [ITER:0]      vld_q;
  logic signed [33:0] x_q [ITER+1];
  logic signed [33:0] y_q [ITER+1];
  logic signed [33:0] z_q [ITER+1];
  logic [SB_W-1:0]    sb_q [ITER+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= 34'sd1 <<< FRAC_BITS;
      y_q[0]  <= $signed({3'b000, r_i});
      z_q[0]  <= '0;
      sb_q[0] <= sb_i;
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_stage
    localparam logic signed [33:0] ANG = atan_step(k - 1, FRAC_BITS);
    logic signed [33:0] xs, ys;
    assign xs = x_q[k-1] >>> (k - 1);
    assign ys = y_q[k-1] >>> (k - 1);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[k-1][33]) begin
          x_q[k] <= x_q[k-1] + ys;
          y_q[k] <= y_q[k-1] - xs;
          z_q[k] <= z_q[k-1] + ANG;
        end else begin
          x_q[k] <= x_q[k-1] - ys;
          y_q[k] <= y_q[k-1] + xs;
          z_q[k] <= z_q[k-1] - ANG;
        end
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ITER-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[ITER];
  assign theta_o = z_q[ITER][31:0];
  assign sb_o    = sb_q[ITER];

endmodule
`default_nettype wire

[src/fisheye_forward_distort.sv]
// Throughput: one request per cycle; the whole pipeline advances unless the result is stalled.
// The 33-stage dividers (focal length, then scale) and the 32-stage square root set most of the depth.
// Reset (async, active low) clears all valid bits and loads the register defaults:
// focal 1.0, center 0.5, distortion coefficients 0. Payload registers are not reset.
`default_nettype none
module fisheye_forward_distort #(
  parameter int FRAC_BITS        = 24,
  parameter int ANGLE_ITERATIONS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] plane_u_i,
  input  wire logic signed [31:0] plane_v_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      warped_u_o,
  output logic signed [31:0]      warped_v_o,
  output logic                    saturated_o
);
  import ffd_pkg::*;

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam int PKT_W = $bits(pkt_t);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [30:0]        fxl_q, fyl_q;
  logic signed [31:0] cx_q, cy_q, k1_q, k2_q, k3_q, k4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fxl_q <= 31'd16777216;
      fyl_q <= 31'd16777216;
      cx_q  <= 32'sd8388608;
      cy_q  <= 32'sd8388608;
      k1_q  <= '0;
      k2_q  <= '0;
      k3_q  <= '0;
      k4_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FOCAL_X:  fxl_q <= cfg_wdata_i[30:0];
        REG_FOCAL_Y:  fyl_q <= cfg_wdata_i[30:0];
        REG_CENTER_X: cx_q  <= cfg_wdata_i;
        REG_CENTER_Y: cy_q  <= cfg_wdata_i;
        REG_DIST_K1:  k1_q  <= cfg_wdata_i;
        REG_DIST_K2:  k2_q  <= cfg_wdata_i;
        REG_DIST_K3:  k3_q  <= cfg_wdata_i;
        REG_DIST_K4:  k4_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register is free or drained.
  logic en;
  logic v16_q;
  assign en          = !v16_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v16_q;

  // ---------------------------------------------------------------------------
  // Stage 1: remove principal point
  // ---------------------------------------------------------------------------
  sat_t               dxs, dys;
  logic signed [31:0] dx_q, dy_q;
  logic               f1_q, v1_q;

  assign dxs = sat64(64'(plane_u_i) - 64'(cx_q));
  assign dys = sat64(64'(plane_v_i) - 64'(cy_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= dxs.val;
      dy_q <= dys.val;
      f1_q <= dxs.ovf | dys.ovf;
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by focal length
  // ---------------------------------------------------------------------------
  logic               vx, vy, xov, yov, xsb, ysb;
  logic signed [31:0] xq, yq;

  ffd_div #(.FRAC_BITS(FRAC_BITS), .SB_W(1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .num_i(dx_q), .den_i(fxl_q),
    .sb_i(f1_q), .valid_o(vx), .quo_o(xq), .ovf_o(xov), .sb_o(xsb)
  );

  ffd_div #(.FRAC_BITS(FRAC_BITS), .SB_W(1)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .num_i(dy_q), .den_i(fyl_q),
    .sb_i(1'b0), .valid_o(vy), .quo_o(yq), .ovf_o(yov), .sb_o(ysb)
  );

  // ---------------------------------------------------------------------------
  // Squares, then their sum
  // ---------------------------------------------------------------------------
  logic signed [63:0] sx_q, sy_q;
  logic signed [31:0] x2_q, y2_q, x3_q, y3_q;
  logic               f2_q, f3_q, v2_q, v3_q;
  logic [63:0]        sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= xq * xq;
      sy_q  <= yq * yq;
      x2_q  <= xq;
      y2_q  <= yq;
      f2_q  <= xsb | ysb | xov | yov;
      sum_q <= $unsigned(sx_q) + $unsigned(sy_q);
      x3_q  <= x2_q;
      y3_q  <= y2_q;
      f3_q  <= f2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Radius
  // ---------------------------------------------------------------------------
  logic        vr;
  logic [31:0] root;
  logic [64:0] rsb;

  ffd_isqrt #(.SB_W(65)) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .rad_i(sum_q),
    .sb_i({x3_q, y3_q, f3_q}), .valid_o(vr), .root_o(root), .sb_o(rsb)
  );

  pkt_t p4_q;
  logic v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q.x    <= rsb[64:33];
      p4_q.y    <= rsb[32:1];
      p4_q.r    <= root[31] ? 31'h7FFFFFFF : root[30:0];
      p4_q.rz   <= root == '0;
      p4_q.fpre <= rsb[0] | root[31];
    end
  end

  // ---------------------------------------------------------------------------
  // theta = atan(r)
  // ---------------------------------------------------------------------------
  logic               vc;
  logic signed [31:0] th_c;
  logic [PKT_W-1:0]   pk_c;

  ffd_cordic #(.FRAC_BITS(FRAC_BITS), .ITER(ANGLE_ITERATIONS), .SB_W(PKT_W)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .r_i(p4_q.r), .sb_i(p4_q),
    .valid_o(vc), .theta_o(th_c), .sb_o(pk_c)
  );

  // ---------------------------------------------------------------------------
  // Polynomial: stages Q1..Q11; Q9 sums and clips, elsewhere multiply and round alternate
  // ---------------------------------------------------------------------------
  pkt_t               pk_q [1:11];
  logic signed [31:0] th_q [1:11];
  logic               fp_q [1:11];
  logic [11:1]        vq_q;
  logic [11:1]        fadd;

  logic signed [63:0] ma_q, mb_q, m6_q, m8_q, mc1_q, mc2_q, mc3_q, mc4_q, mp_q;
  logic signed [31:0] t2_q, t2b_q, t4_q, t2c_q, t6_q, t8_q;
  logic signed [31:0] c1_q, c2_q, c1b_q, c2b_q, c3_q, c4_q, c1c_q, c2c_q;
  logic signed [31:0] poly_q, thd_q;

  sat_t r2, r4, r6, r8, rc1, rc2, rc3, rc4, rpoly, rthd;

  assign r2    = fx_round(ma_q, FRAC_BITS);
  assign r4    = fx_round(mb_q, FRAC_BITS);
  assign r6    = fx_round(m6_q, FRAC_BITS);
  assign r8    = fx_round(m8_q, FRAC_BITS);
  assign rc1   = fx_round(mc1_q, FRAC_BITS);
  assign rc2   = fx_round(mc2_q, FRAC_BITS);
  assign rc3   = fx_round(mc3_q, FRAC_BITS);
  assign rc4   = fx_round(mc4_q, FRAC_BITS);
  assign rpoly = sat64(ONE + 64'(c1c_q) + 64'(c2c_q) + 64'(c3_q) + 64'(c4_q));
  assign rthd  = fx_round(mp_q, FRAC_BITS);

  always_comb begin
    fadd     = '0;
    fadd[2]  = r2.ovf;
    fadd[4]  = r4.ovf;
    fadd[6]  = r6.ovf | r8.ovf | rc1.ovf | rc2.ovf;
    fadd[8]  = rc3.ovf | rc4.ovf;
    fadd[9]  = rpoly.ovf;
    fadd[11] = rthd.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_q[1] <= pk_c;
      th_q[1] <= th_c;
      fp_q[1] <= 1'b0;
      for (int k = 2; k <= 11; k++) begin
        pk_q[k] <= pk_q[k-1];
        th_q[k] <= th_q[k-1];
        fp_q[k] <= fp_q[k-1] | fadd[k];
      end
      ma_q   <= th_c * th_c;
      t2_q   <= r2.val;
      mb_q   <= t2_q * t2_q;
      t2b_q  <= t2_q;
      t4_q   <= r4.val;
      t2c_q  <= t2b_q;
      m6_q   <= t4_q * t2c_q;
      m8_q   <= t4_q * t4_q;
      mc1_q  <= k1_q * t2c_q;
      mc2_q  <= k2_q * t4_q;
      t6_q   <= r6.val;
      t8_q   <= r8.val;
      c1_q   <= rc1.val;
      c2_q   <= rc2.val;
      mc3_q  <= k3_q * t6_q;
      mc4_q  <= k4_q * t8_q;
      c1b_q  <= c1_q;
      c2b_q  <= c2_q;
      c3_q   <= rc3.val;
      c4_q   <= rc4.val;
      c1c_q  <= c1b_q;
      c2c_q  <= c2b_q;
      poly_q <= rpoly.val;
      mp_q   <= th_q[9] * poly_q;
      thd_q  <= rthd.val;
    end
  end

  // ---------------------------------------------------------------------------
  // scale = theta_d / r
  // ---------------------------------------------------------------------------
  logic               vs, sov;
  logic signed [31:0] scale;
  logic [PKT_W:0]     ssb;
  pkt_t               pk_s;

  ffd_div #(.FRAC_BITS(FRAC_BITS), .SB_W(PKT_W + 1)) u_div_s (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vq_q[11]), .num_i(thd_q), .den_i(pk_q[11].r),
    .sb_i({pk_q[11], fp_q[11]}), .valid_o(vs), .quo_o(scale), .ovf_o(sov), .sb_o(ssb)
  );

  assign pk_s = ssb[PKT_W:1];

  // ---------------------------------------------------------------------------
  // Q12..Q16: re-apply focal length, scale, add center, output register
  // ---------------------------------------------------------------------------
  pkt_t               pk12_q, pk13_q, pk14_q, pk15_q;
  logic               fp12_q, fp13_q, fp14_q, fp15_q;
  logic               v12_q, v13_q, v14_q, v15_q;
  logic signed [63:0] mx_q, my_q, nx_q, ny_q;
  logic signed [31:0] sc12_q, sc13_q, ax_q, ay_q, bx_q, by_q;
  sat_t               rax, ray, rbx, rby, rwu, rwv;

  assign rax = fx_round(mx_q, FRAC_BITS);
  assign ray = fx_round(my_q, FRAC_BITS);
  assign rbx = fx_round(nx_q, FRAC_BITS);
  assign rby = fx_round(ny_q, FRAC_BITS);
  assign rwu = sat64(64'(bx_q) + 64'(cx_q));
  assign rwv = sat64(64'(by_q) + 64'(cy_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= $signed({1'b0, fxl_q}) * pk_s.x;
      my_q   <= $signed({1'b0, fyl_q}) * pk_s.y;
      sc12_q <= scale;
      pk12_q <= pk_s;
      fp12_q <= ssb[0] | sov;

      ax_q   <= rax.val;
      ay_q   <= ray.val;
      sc13_q <= sc12_q;
      pk13_q <= pk12_q;
      fp13_q <= fp12_q | rax.ovf | ray.ovf;

      nx_q   <= ax_q * sc13_q;
      ny_q   <= ay_q * sc13_q;
      pk14_q <= pk13_q;
      fp14_q <= fp13_q;

      bx_q   <= rbx.val;
      by_q   <= rby.val;
      pk15_q <= pk14_q;
      fp15_q <= fp14_q | rbx.ovf | rby.ovf;

      // zero radius returns the center; later clips do not count
      if (pk15_q.rz) begin
        warped_u_o  <= cx_q;
        warped_v_o  <= cy_q;
        saturated_o <= pk15_q.fpre;
      end else begin
        warped_u_o  <= rwu.val;
        warped_v_o  <= rwv.val;
        saturated_o <= pk15_q.fpre | fp15_q | rwu.ovf | rwv.ovf;
      end
    end
  end

  // Valid bits of the stages owned here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      vq_q  <= '0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
      v14_q <= 1'b0;
      v15_q <= 1'b0;
      v16_q <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= vx & vy;
      v3_q  <= v2_q;
      v4_q  <= vr;
      vq_q  <= {vq_q[10:1], vc};
      v12_q <= vs;
      v13_q <= v12_q;
      v14_q <= v13_q;
      v15_q <= v14_q;
      v16_q <= v15_q;
    end
  end

endmodule
`default_nettype wire

[src/ffd_checker.sv]
// Port-level checker for fisheye_forward_distort, attached by the bind below.
// Sees only top-level ports; no package use.
`default_nettype none
module ffd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] warped_u_o,
  input wire logic signed [31:0] warped_v_o,
  input wire logic               saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(warped_u_o) && $stable(warped_v_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while pipeline stalled");

  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready with empty output register");

endmodule

bind fisheye_forward_distort ffd_checker u_ffd_checker (.*);
`default_nettype wire
